>>> rtl/fpt_pkg.sv
// Shared types, codes and constants of the frame pacing throttle.
package fpt_pkg;

    localparam int DIV_W    = 48;
    localparam int DVSR_W   = 32;
    localparam int DCNT_W   = 6;
    localparam int PERIOD_W = 31;
    localparam int P4_W     = 33;
    localparam int RATE_W   = 22;

    localparam logic [1:0] OP_CHECK = 2'd0;
    localparam logic [1:0] OP_UP    = 2'd1;
    localparam logic [1:0] OP_DOWN  = 2'd2;

    localparam logic [1:0] ST_PROCEED = 2'd0;
    localparam logic [1:0] ST_SLEEP   = 2'd1;
    localparam logic [1:0] ST_YIELD   = 2'd2;

    localparam logic [0:0] CFG_TICK_FREQ = 1'd0;
    localparam logic [0:0] CFG_FAST_FWD  = 1'd1;

    localparam logic [RATE_W-1:0] NOMINAL_RATE = 22'd3294723;
    localparam logic [RATE_W-1:0] MIN_RATE     = 22'd245760;
    localparam logic [8:0]        UNITY_SCALE  = 9'd256;
    localparam logic [8:0]        MIN_SCALE    = 9'd16;
    localparam logic [31:0]       TICK_RESET   = 32'd1000;
    localparam logic [9:0]        MS_PER_S     = 10'd1000;
    localparam logic [6:0]        MAX_WAIT     = 7'd100;

    typedef struct packed {
        logic capture_in;
        logic start_pdiv;
        logic capture_period;
        logic compare;
        logic act;
        logic capture_ms;
        logic apply;
        logic load_out;
    } fpt_cmd_t;

    typedef struct packed {
        logic paced;
        logic div_done;
        logic early;
        logic out_free;
    } fpt_sts_t;

    function automatic logic [RATE_W-1:0] rate_of(input logic [8:0] scale);
        logic [RATE_W-1:0] r;
        case (scale)
            9'd256:  r = NOMINAL_RATE;
            9'd128:  r = 22'd1647361;
            9'd64:   r = 22'd823680;
            9'd32:   r = 22'd411840;
            default: r = MIN_RATE;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/fpt_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
module fpt_div
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [fpt_pkg::DIV_W-1:0]    dividend,
    input  logic [fpt_pkg::DVSR_W-1:0]   divisor,
    output logic                         done,
    output logic [fpt_pkg::DIV_W-1:0]    quotient,
    output logic [fpt_pkg::DVSR_W-1:0]   remainder
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [fpt_pkg::DCNT_W-1:0]    cnt_reg;
    logic [fpt_pkg::DIV_W-1:0]     quo_reg;
    logic [fpt_pkg::DVSR_W-1:0]    rem_reg;
    logic [fpt_pkg::DVSR_W-1:0]    dvsr_reg;
    logic [fpt_pkg::DVSR_W:0]      rem_sh;
    logic [fpt_pkg::DVSR_W:0]      rem_sub;
    logic                          ge;

    assign rem_sh  = {rem_reg, quo_reg[fpt_pkg::DIV_W-1]};
    assign ge      = rem_sh >= {1'b0, dvsr_reg};
    assign rem_sub = rem_sh - {1'b0, dvsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == fpt_pkg::DCNT_W'(fpt_pkg::DIV_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg  <= dividend;
            rem_reg  <= '0;
            dvsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[fpt_pkg::DIV_W-2:0], ge};
            rem_reg <= ge ? rem_sub[fpt_pkg::DVSR_W-1:0] : rem_sh[fpt_pkg::DVSR_W-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

>>> rtl/fpt_dp.sv
// Datapath: config, pacing state, period and wait arithmetic, result register.
module fpt_dp
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  fpt_pkg::fpt_cmd_t    cmd,
    output fpt_pkg::fpt_sts_t    sts,
    input  logic                 cfg_we,
    input  logic [0:0]           cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic [1:0]           op,
    input  logic [63:0]          now,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           status,
    output logic [6:0]           wait_ms,
    output logic                 behind,
    output logic                 slow,
    output logic [8:0]           speed_scale
);

    logic [31:0]                     tick_freq_reg;
    logic                            ff_reg;
    logic [8:0]                      scale_reg;
    logic [63:0]                     last_reg;
    logic                            behind_reg;
    logic [1:0]                      op_reg;
    logic [63:0]                     now_reg;
    logic [63:0]                     elapsed_reg;
    logic [fpt_pkg::PERIOD_W-1:0]    period_reg;
    logic [fpt_pkg::P4_W-1:0]        period4_reg;
    logic                            early_reg;
    logic                            resync_reg;
    logic                            late2_reg;
    logic [fpt_pkg::PERIOD_W-1:0]    diff_reg;
    logic [1:0]                      res_status_reg;
    logic [6:0]                      res_wait_reg;
    logic                            out_valid_reg;
    logic [1:0]                      out_status_reg;
    logic [6:0]                      out_wait_reg;
    logic                            out_behind_reg;
    logic                            out_slow_reg;
    logic [8:0]                      out_scale_reg;

    logic                            div_start;
    logic [fpt_pkg::DIV_W-1:0]       div_dvd;
    logic [fpt_pkg::DVSR_W-1:0]      div_dvsr;
    logic                            div_done;
    logic [fpt_pkg::DIV_W-1:0]       div_quo;
    logic [fpt_pkg::DVSR_W-1:0]      div_rem;

    logic [fpt_pkg::RATE_W-1:0]      rate;
    logic [fpt_pkg::RATE_W+1:0]      rem4;
    logic [fpt_pkg::RATE_W+1:0]      rate_x1;
    logic [fpt_pkg::RATE_W+1:0]      rate_x2;
    logic [fpt_pkg::RATE_W+1:0]      rate_x3;
    logic [1:0]                      frac;
    logic [40:0]                     ms_dvd;
    logic [8:0]                      scale_up;
    logic [8:0]                      scale_dn;

    assign rate    = fpt_pkg::rate_of(scale_reg);
    assign rem4    = {div_rem[fpt_pkg::RATE_W-1:0], 2'b00};
    assign rate_x1 = {2'b00, rate};
    assign rate_x2 = {1'b0, rate, 1'b0};
    assign rate_x3 = rate_x1 + rate_x2;
    assign frac    = (rem4 >= rate_x3) ? 2'd3 :
                     (rem4 >= rate_x2) ? 2'd2 :
                     (rem4 >= rate_x1) ? 2'd1 : 2'd0;
    assign ms_dvd  = {10'd0, diff_reg} * {31'd0, fpt_pkg::MS_PER_S};

    assign div_start = cmd.start_pdiv || (cmd.act && early_reg);
    assign div_dvd   = cmd.start_pdiv ? {tick_freq_reg, 16'd0} : {7'd0, ms_dvd};
    assign div_dvsr  = cmd.start_pdiv ? {10'd0, rate} : tick_freq_reg;

    assign scale_up = (scale_reg == fpt_pkg::UNITY_SCALE) ? fpt_pkg::UNITY_SCALE
                                                          : {scale_reg[7:0], 1'b0};
    assign scale_dn = (scale_reg <= 9'd32) ? fpt_pkg::MIN_SCALE : {1'b0, scale_reg[8:1]};

    fpt_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dvd),
        .divisor   (div_dvsr),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // config and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_freq_reg <= fpt_pkg::TICK_RESET;
            ff_reg        <= 1'b0;
            scale_reg     <= fpt_pkg::UNITY_SCALE;
            last_reg      <= '0;
            behind_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    fpt_pkg::CFG_TICK_FREQ: tick_freq_reg <= cfg_data;
                    fpt_pkg::CFG_FAST_FWD:  ff_reg        <= cfg_data[0];
                    default:                ;
                endcase
            end
            if (cmd.start_pdiv)
                behind_reg <= 1'b0;
            if (cmd.act && !early_reg)
            begin
                if (resync_reg)
                    last_reg <= now_reg;
                else
                begin
                    last_reg   <= last_reg + {33'd0, period_reg};
                    behind_reg <= late2_reg;
                end
            end
            if (cmd.apply)
            begin
                case (op_reg)
                    fpt_pkg::OP_UP:   scale_reg <= scale_up;
                    fpt_pkg::OP_DOWN: scale_reg <= scale_dn;
                    default:          ;
                endcase
            end
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture_in)
        begin
            op_reg  <= op;
            now_reg <= now;
        end
        if (cmd.start_pdiv)
            elapsed_reg <= now_reg - last_reg;
        if (cmd.capture_period)
        begin
            period_reg  <= div_quo[fpt_pkg::PERIOD_W-1:0];
            period4_reg <= {div_quo[fpt_pkg::PERIOD_W-1:0], frac};
        end
        if (cmd.compare)
        begin
            early_reg  <= elapsed_reg < {33'd0, period_reg};
            resync_reg <= elapsed_reg >= {31'd0, period4_reg};
            late2_reg  <= elapsed_reg >= {32'd0, period_reg, 1'b0};
            diff_reg   <= period_reg - elapsed_reg[fpt_pkg::PERIOD_W-1:0];
        end
        if (cmd.apply || (cmd.act && !early_reg))
        begin
            res_status_reg <= fpt_pkg::ST_PROCEED;
            res_wait_reg   <= '0;
        end
        if (cmd.capture_ms)
        begin
            if (div_quo > {41'd0, fpt_pkg::MAX_WAIT})
            begin
                res_status_reg <= fpt_pkg::ST_YIELD;
                res_wait_reg   <= fpt_pkg::MAX_WAIT;
            end
            else
            begin
                res_status_reg <= fpt_pkg::ST_SLEEP;
                res_wait_reg   <= div_quo[6:0];
            end
        end
        if (cmd.load_out)
        begin
            out_status_reg <= res_status_reg;
            out_wait_reg   <= res_wait_reg;
            out_behind_reg <= behind_reg;
            out_slow_reg   <= scale_reg != fpt_pkg::UNITY_SCALE;
            out_scale_reg  <= scale_reg;
        end
    end

    assign sts.paced    = (op_reg == fpt_pkg::OP_CHECK) && !ff_reg;
    assign sts.div_done = div_done;
    assign sts.early    = early_reg;
    assign sts.out_free = !out_valid_reg || !out_stall;

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign wait_ms     = out_wait_reg;
    assign behind      = out_behind_reg;
    assign slow        = out_slow_reg;
    assign speed_scale = out_scale_reg;

endmodule

>>> rtl/fpt_ctrl.sv
// Controller: sequences one word through divide, compare and update steps.
module fpt_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  fpt_pkg::fpt_sts_t    sts,
    output fpt_pkg::fpt_cmd_t    cmd
);

    typedef enum logic [7:0]
    {
        S_IDLE  = 8'b0000_0001,
        S_START = 8'b0000_0010,
        S_PWAIT = 8'b0000_0100,
        S_CMP   = 8'b0000_1000,
        S_ACT   = 8'b0001_0000,
        S_MWAIT = 8'b0010_0000,
        S_APPLY = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture_in = 1'b1;
                    state_next     = S_START;
                end
            end
            S_START:
            begin
                if (sts.paced)
                begin
                    cmd.start_pdiv = 1'b1;
                    state_next     = S_PWAIT;
                end
                else
                    state_next = S_APPLY;
            end
            S_PWAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.capture_period = 1'b1;
                    state_next         = S_CMP;
                end
            end
            S_CMP:
            begin
                cmd.compare = 1'b1;
                state_next  = S_ACT;
            end
            S_ACT:
            begin
                cmd.act    = 1'b1;
                state_next = sts.early ? S_MWAIT : S_DONE;
            end
            S_MWAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.capture_ms = 1'b1;
                    state_next     = S_DONE;
                end
            end
            S_APPLY:
            begin
                cmd.apply  = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall = state_reg != S_IDLE;

endmodule

>>> rtl/frame_pacing_throttle.sv
// Frame pacing throttle top level: paced frame checks and speed stepping.
// Sequence: speed ops and unpaced checks go straight to the result register; a paced
// check runs a period division, a compare and, if early, a second division for the wait.
// One word at a time; a new word is taken once the previous result sits in the
// output register, so the rate is set by the shared divider and by out_stall.
// Reset: async active-low; scale 256, last frame time 0, tick_freq 1000, no output.
module frame_pacing_throttle
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [0:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    input  logic         in_valid,
    output logic         in_stall,
    input  logic [1:0]   op,
    input  logic [63:0]  now,
    output logic         out_valid,
    input  logic         out_stall,
    output logic [1:0]   status,
    output logic [6:0]   wait_ms,
    output logic         behind,
    output logic         slow,
    output logic [8:0]   speed_scale
);

    fpt_pkg::fpt_cmd_t cmd;
    fpt_pkg::fpt_sts_t sts;

    assign cfg_ready = 1'b1;

    fpt_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    fpt_dp u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .op          (op),
        .now         (now),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .wait_ms     (wait_ms),
        .behind      (behind),
        .slow        (slow),
        .speed_scale (speed_scale)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("accepted word did not make the block busy");

    a_scale_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (speed_scale == 9'd16 || speed_scale == 9'd32 ||
                       speed_scale == 9'd64 || speed_scale == 9'd128 ||
                       speed_scale == 9'd256))
        else $error("speed scale off the power-of-two ladder");

    a_slow_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (slow == (speed_scale != fpt_pkg::UNITY_SCALE)))
        else $error("slow flag disagrees with speed scale");

    a_wait_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((status == fpt_pkg::ST_PROCEED && wait_ms == 7'd0) ||
                       (status == fpt_pkg::ST_SLEEP && wait_ms <= fpt_pkg::MAX_WAIT) ||
                       (status == fpt_pkg::ST_YIELD && wait_ms == fpt_pkg::MAX_WAIT)))
        else $error("wait_ms inconsistent with status");

endmodule
